[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock with an active-low reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form, antecedent and consequent given apart
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/ipacl_pkg.sv]
// ----------------------------------------------------------------------------
// ipacl_pkg
// types, codes and the prefix mask helper of the ip prefix access list
// ----------------------------------------------------------------------------
package ipacl_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_VERIFY   = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISS       = 2'd1,
    ST_BAD_PREFIX = 2'd2,
    ST_FULL       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // one stored rule, also used for the normalised key of a word
  typedef struct packed {
    logic        any;
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix;
  } entry_t;

  // leading-bits mask over the 128-bit address, v4 lives in bits 31..0
  function automatic logic [127:0] prefix_mask(input logic fam, input logic [7:0] p);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 128; i++) begin
      if (fam) begin
        m[127-i] = (i < int'(p));
      end else if (i < 32) begin
        m[31-i] = (i < int'(p));
      end
    end
    return m;
  endfunction

endpackage

[src/ip_prefix_access_list.sv]
// ----------------------------------------------------------------------------
// ip_prefix_access_list
// bounded table of ipv4/ipv6 prefix rules with add, delete and verify
// an accepted word is held; an add walks the valid bits until the lowest
// free slot, a delete or verify reads the rule memory one entry a cycle
// until the first hit, and the result is then registered at the output
// one word at a time; a new word is taken while a result waits at the output
// reset clears the valid bits and the count; the rule memory is not cleared
// ----------------------------------------------------------------------------
module ip_prefix_access_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        is_any_i,
  input  logic        family_i,
  input  logic [63:0] address_high_i,
  input  logic [63:0] address_low_i,
  input  logic [7:0]  prefix_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);
  import ipacl_pkg::*;

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   out_load;

  // word held for the walk
  op_e     op_q;
  entry_t  key_q;
  status_e res_status_q;

  // table state: valid bits in flops, rule bodies in a memory
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [4:0]               count_q;
  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rdata_q;

  // walk control
  logic [IDX_W-1:0] idx_q;
  logic             issue_done_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;

  // output register
  logic       out_valid_q;
  status_e    out_status_q;
  logic [4:0] out_count_q;

  // ---------------------------------------------------------------------------
  // normalise the incoming word
  // ---------------------------------------------------------------------------
  op_e        in_op;
  logic [7:0] max_prefix;
  logic       prefix_bad;
  logic       early;
  status_e    early_status;
  entry_t     in_key;

  assign in_op      = op_e'(operation_i);
  assign max_prefix = family_i ? V6_MAX_PREFIX : V4_MAX_PREFIX;
  assign prefix_bad = !is_any_i && (prefix_length_i > max_prefix);

  always_comb begin
    if (is_any_i && (in_op != OP_VERIFY)) begin
      // any rule: stored with family, address and prefix all zero
      in_key     = '0;
      in_key.any = 1'b1;
    end else begin
      in_key.any       = is_any_i;
      in_key.family    = family_i;
      in_key.addr_high = family_i ? address_high_i : 64'd0;
      in_key.addr_low  = family_i ? address_low_i : {32'd0, address_low_i[31:0]};
      in_key.prefix    = (prefix_length_i == 8'd0) ? max_prefix : prefix_length_i;
    end
  end

  // words settled without touching the table
  always_comb begin
    early        = 1'b0;
    early_status = ST_MISS;
    unique case (in_op)
      OP_ADD: begin
        early        = prefix_bad;
        early_status = ST_BAD_PREFIX;
      end
      OP_DELETE: begin
        early        = prefix_bad;
        early_status = ST_MISS;
      end
      OP_VERIFY: begin
        early        = 1'b0;
        early_status = ST_MISS;
      end
      default: begin
        early        = 1'b1;
        early_status = ST_MISS;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // walk over the table
  // ---------------------------------------------------------------------------
  logic is_add;
  logic add_free;
  logic match_hit;
  logic hit;
  logic scan_fin;
  logic do_issue;

  assign is_add   = (op_q == OP_ADD);
  assign add_free = is_add && !valid_q[idx_q];

  ipacl_match u_match (
    .is_verify_i (op_q == OP_VERIFY),
    .key_i       (key_q),
    .entry_i     (rdata_q),
    .hit_o       (match_hit)
  );

  // read data belongs to pend_idx_q, a slot only counts while valid
  assign hit = pend_q && valid_q[pend_idx_q] && match_hit;

  always_comb begin
    if (is_add) begin
      scan_fin = !valid_q[idx_q] || (idx_q == LAST_IDX);
    end else begin
      scan_fin = pend_q && (hit || (pend_idx_q == LAST_IDX));
    end
  end

  assign do_issue = (state_q == S_SCAN) && !is_add && !issue_done_q && !scan_fin;

  // ---------------------------------------------------------------------------
  // sequencer: next state and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = early ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_fin) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_SCAN:  in_ready_o = 1'b0;
      S_DONE:  out_load   = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // table control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        idx_q        <= '0;
        issue_done_q <= 1'b0;
        pend_q       <= 1'b0;
      end else if (state_q == S_SCAN) begin
        pend_q     <= do_issue;
        pend_idx_q <= idx_q;
        if (is_add) begin
          if (add_free) begin
            valid_q[idx_q] <= 1'b1;
            count_q        <= count_q + 5'd1;
          end else if (!scan_fin) begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end else begin
          if (hit && (op_q == OP_DELETE)) begin
            valid_q[pend_idx_q] <= 1'b0;
            count_q             <= count_q - 5'd1;
          end
          if (do_issue) begin
            if (idx_q == LAST_IDX) begin
              issue_done_q <= 1'b1;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
      end

      // output register frees as soon as the word is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= in_op;
      key_q        <= in_key;
      res_status_q <= early_status;
    end else if ((state_q == S_SCAN) && scan_fin) begin
      if (is_add) begin
        res_status_q <= add_free ? ST_OK : ST_FULL;
      end else begin
        res_status_q <= hit ? ST_OK : ST_MISS;
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
    end
  end

  // rule memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && add_free) begin
      mem_q[idx_q] <= key_q;
    end
    rdata_q <= mem_q[idx_q];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

endmodule

[src/ipacl_match.sv]
// ----------------------------------------------------------------------------
// ipacl_match
// compares one stored rule against the key of the current word
// ----------------------------------------------------------------------------
module ipacl_match (
  input  logic             is_verify_i,
  input  ipacl_pkg::entry_t key_i,
  input  ipacl_pkg::entry_t entry_i,
  output logic             hit_o
);
  import ipacl_pkg::*;

  logic [127:0] diff;
  logic [127:0] mask;
  logic         prefix_hit;
  logic         equal_hit;

  assign diff = {entry_i.addr_high, entry_i.addr_low} ^ {key_i.addr_high, key_i.addr_low};
  assign mask = prefix_mask(entry_i.family, entry_i.prefix);

  assign prefix_hit = entry_i.any ||
                      ((entry_i.family == key_i.family) && ((diff & mask) == '0));

  assign equal_hit = (entry_i.any == key_i.any) &&
                     (key_i.any || ((entry_i.family == key_i.family) && (diff == '0) &&
                                    (entry_i.prefix == key_i.prefix)));

  assign hit_o = is_verify_i ? prefix_hit : equal_hit;

endmodule

[src/ipacl_checker.sv]
// ----------------------------------------------------------------------------
// ipacl_checker
// port-level checks of the ip prefix access list, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipacl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [4:0]  entry_count_o
);
  import ipacl_pkg::*;

  logic in_word;
  logic out_stall;

  assign in_word   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // one word at a time: no second word right behind an accepted one
  `ASSERT_PROP(a_one_at_a_time, clk_i, rst_ni, in_word |=> !in_ready_o, "word accepted while busy")

  // a full table reports exactly its capacity
  `ASSERT_IMPL(a_full_count, clk_i, rst_ni, out_valid_o && (status_e'(status_o) == ST_FULL),
               entry_count_o == 5'(TABLE_ENTRIES), "table full with wrong count")

  // a stalled result word stays valid and unchanged
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o, "result dropped")
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni,
               out_stall |=> ($stable(status_o) && $stable(entry_count_o)), "result changed")

endmodule

bind ip_prefix_access_list ipacl_checker u_ipacl_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ip prefix access list: a short table of
// directed words, then a long run of random add, delete and verify words
// shaped around the rules the table really holds, every unpinned result compared
// against a behavioural model of the rule table kept inside the bench
// ----------------------------------------------------------------------------
module tb_top;
  import ipacl_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TAIL_CYCLES  = 40;
  // room for every word plus random gaps and stalls on both sides
  localparam int unsigned CYCLE_LIMIT  = 300000;

  typedef struct {
    op_e         op;
    logic        any;
    logic        fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  plen;
  } word_t;

  typedef struct {
    status_e    status;
    logic [4:0] count;
  } verdict_t;

  // a directed row; pinned rows carry their result typed in by hand
  typedef struct {
    word_t      w;
    int         reps;
    bit         pinned;
    status_e    status;
    logic [4:0] count;
  } dir_row_t;

  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  // clock, reset and the driven side of the block
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [1:0]  operation     = '0;
  logic        is_any        = 1'b0;
  logic        family        = 1'b0;
  logic [63:0] address_high  = '0;
  logic [63:0] address_low   = '0;
  logic [7:0]  prefix_length = '0;
  logic        out_ready     = 1'b0;

  // hand-typed result travelling with the word being driven
  logic        pin_valid  = 1'b0;
  status_e     pin_status = ST_OK;
  logic [4:0]  pin_count  = '0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  bit          steady = 1'b0;   // no idling on either side while set
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  verdict_t    pending_verdicts[$];

  // model copy of the rule table
  bit          acl_valid  [TABLE_ENTRIES];
  bit          acl_any    [TABLE_ENTRIES];
  bit          acl_family [TABLE_ENTRIES];
  logic [63:0] acl_hi     [TABLE_ENTRIES];
  logic [63:0] acl_lo     [TABLE_ENTRIES];
  logic [7:0]  acl_plen   [TABLE_ENTRIES];

  always #1 clk = ~clk;

  ip_prefix_access_list i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .is_any_i        (is_any),
    .family_i        (family),
    .address_high_i  (address_high),
    .address_low_i   (address_low),
    .prefix_length_i (prefix_length),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .entry_count_o   (entry_count)
  );

  // ---------------------------------------------------------------------------
  // rule table model: applies one word and returns the status and count
  // ---------------------------------------------------------------------------
  function automatic verdict_t acl_apply(word_t w);
    verdict_t     v;
    logic         any, fam, bad;
    logic [63:0]  hi, lo;
    logic [7:0]   plen, pmax;
    logic [127:0] diff;
    int           slot, i;
    any  = w.any;
    fam  = w.fam;
    hi   = w.hi;
    lo   = w.lo;
    plen = w.plen;
    bad  = 1'b0;
    pmax = fam ? V6_MAX_PREFIX : V4_MAX_PREFIX;
    // normalise the key: an any rule drops every address field, v4 keeps
    // only the low 32 bits, prefix zero stands for the full length
    if (any) begin
      fam  = 1'b0;
      hi   = '0;
      lo   = '0;
      plen = '0;
    end else begin
      if (!fam) begin
        hi = '0;
        lo = {32'd0, lo[31:0]};
      end
      if (plen == 8'd0) begin
        plen = pmax;
      end else if (plen > pmax) begin
        bad = 1'b1;
      end
    end

    v.status = ST_MISS;
    slot = -1;
    case (w.op)
      OP_ADD: begin
        if (bad) begin
          v.status = ST_BAD_PREFIX;
        end else begin
          v.status = ST_FULL;
          for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && !acl_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            acl_valid[slot]  = 1'b1;
            acl_any[slot]    = any;
            acl_family[slot] = fam;
            acl_hi[slot]     = hi;
            acl_lo[slot]     = lo;
            acl_plen[slot]   = plen;
            v.status = ST_OK;
          end
        end
      end
      OP_DELETE: begin
        // a bad prefix can never equal a stored rule
        if (!bad) begin
          for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && acl_valid[i] && acl_any[i] == any &&
                (any || (acl_family[i] == fam && acl_hi[i] == hi &&
                         acl_lo[i] == lo && acl_plen[i] == plen))) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            acl_valid[slot] = 1'b0;
            v.status = ST_OK;
          end
        end
      end
      OP_VERIFY: begin
        hi = w.fam ? w.hi : '0;
        lo = w.fam ? w.lo : {32'd0, w.lo[31:0]};
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (acl_valid[i]) begin
            if (acl_any[i]) begin
              v.status = ST_OK;
            end else if (acl_family[i] == w.fam) begin
              // only the leading prefix bits of the rule take part
              diff = {acl_hi[i], acl_lo[i]} ^ {hi, lo};
              if (w.fam ? ((diff >> (128 - acl_plen[i])) == '0)
                        : ((diff[31:0] >> (32 - acl_plen[i])) == '0)) begin
                v.status = ST_OK;
              end
            end
          end
        end
      end
      default: ;  // reserved code leaves the table alone
    endcase

    v.count = '0;
    for (i = 0; i < TABLE_ENTRIES; i++) v.count += 5'(acl_valid[i]);
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch, %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // drive one word from a falling edge, hold it until taken, end on a falling
  // edge; valid only drops when an idle cycle follows
  // ---------------------------------------------------------------------------
  task automatic send_word(input word_t w, input bit pinned, input status_e st,
                           input logic [4:0] cnt);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= w.op;
    is_any        <= w.any;
    family        <= w.fam;
    address_high  <= w.hi;
    address_low   <= w.lo;
    prefix_length <= w.plen;
    pin_valid     <= pinned;
    pin_status    <= st;
    pin_count     <= cnt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // result side back-pressure
  always @(negedge clk) out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // ---------------------------------------------------------------------------
  // monitor: a taken word is run through the model and queued, a taken
  // result is compared field by field with the oldest queued one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    verdict_t v;
    word_t    w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch($sformatf("result with nothing outstanding, status %0d count %0d",
                                  status, entry_count));
        end else begin
          v = pending_verdicts.pop_front();
          if (status !== v.status) begin
            flag_mismatch($sformatf("status expected %s got %0d", v.status.name(), status));
          end
          if (entry_count !== v.count) begin
            flag_mismatch($sformatf("entry_count expected %0d got %0d", v.count,
                                    entry_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        w.op   = op_e'(operation);
        w.any  = is_any;
        w.fam  = family;
        w.hi   = address_high;
        w.lo   = address_low;
        w.plen = prefix_length;
        v = acl_apply(w);
        // the model still tracks pinned words, only the check value differs
        if (pin_valid) begin
          v.status = pin_status;
          v.count  = pin_count;
        end
        pending_verdicts.push_back(v);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ip_prefix_access_list test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed words: empty table, reserved code, bad prefixes, v6 rules at
  // both prefix extremes, v4 /8 and /32 rules, any rules, delete misses, duplicates,
  // then a fill up to a full table
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [26] = '{
    // verify and delete on an empty table deny
    '{'{OP_VERIFY,   1'b0, 1'b0, 64'h0, 64'h0a00_0001, 8'd0}, 1, 1'b1, ST_MISS, 5'd0},
    '{'{OP_DELETE,   1'b1, 1'b0, 64'h0, 64'h0, 8'd0}, 1, 1'b1, ST_MISS, 5'd0},
    '{'{OP_RESERVED, 1'b0, 1'b1, ONES, ONES, 8'd255}, 1, 1'b1, ST_MISS, 5'd0},
    // prefixes beyond the family width
    '{'{OP_ADD,      1'b0, 1'b0, 64'h0, 64'h0a00_0000, 8'd33}, 1, 1'b1, ST_BAD_PREFIX, 5'd0},
    '{'{OP_ADD,      1'b0, 1'b1, ONES, ONES, 8'd129}, 1, 1'b1, ST_BAD_PREFIX, 5'd0},
    '{'{OP_ADD,      1'b0, 1'b0, 64'h0, 64'h0, 8'd255}, 1, 1'b1, ST_BAD_PREFIX, 5'd0},
    // v4 /8 rule, unused upper bits set and ignored
    '{'{OP_ADD,      1'b0, 1'b0, 64'hffff_0000_ffff_0000, 64'hffff_ffff_0a01_0203, 8'd8},
      1, 1'b1, ST_OK, 5'd1},
    '{'{OP_VERIFY,   1'b1, 1'b0, 64'h0123_4567_89ab_cdef, 64'h0000_0000_0ac8_0001, 8'd77},
      1, 1'b1, ST_OK, 5'd1},
    // same bits in the other family never match
    '{'{OP_VERIFY,   1'b0, 1'b1, 64'h0, 64'h0a01_0203, 8'd0}, 1, 1'b1, ST_MISS, 5'd1},
    // v6 full length, exact match only
    '{'{OP_ADD,      1'b0, 1'b1, ONES, ONES, 8'd0}, 1, 1'b1, ST_OK, 5'd2},
    '{'{OP_VERIFY,   1'b0, 1'b1, ONES, ONES, 8'd0}, 1, 1'b1, ST_OK, 5'd2},
    '{'{OP_VERIFY,   1'b0, 1'b1, ONES, 64'hffff_ffff_ffff_fffe, 8'd0}, 1, 1'b1, ST_MISS, 5'd2},
    // v6 one-bit prefix
    '{'{OP_ADD,      1'b0, 1'b1, 64'h8000_0000_0000_0000, 64'h0, 8'd1}, 1, 1'b1, ST_OK, 5'd3},
    '{'{OP_VERIFY,   1'b0, 1'b1, 64'hc0de_0000_0000_0001, 64'h1234, 8'd0},
      1, 1'b1, ST_OK, 5'd3},
    // delete with a bad prefix is a plain miss
    '{'{OP_DELETE,   1'b0, 1'b1, ONES, ONES, 8'd200}, 1, 1'b1, ST_MISS, 5'd3},
    // any rule: address fields and prefix ignored, accepts everything
    '{'{OP_ADD,      1'b1, 1'b1, ONES, ONES, 8'd255}, 1, 1'b1, ST_OK, 5'd4},
    '{'{OP_VERIFY,   1'b0, 1'b0, 64'h0, 64'h0000_0000_c0a8_0001, 8'd0}, 1, 1'b1, ST_OK, 5'd4},
    '{'{OP_DELETE,   1'b1, 1'b1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 8'd17},
      1, 1'b1, ST_OK, 5'd3},
    // delete must match the stored prefix, not the full length
    '{'{OP_DELETE,   1'b0, 1'b0, 64'h0, 64'h0a01_0203, 8'd0}, 1, 1'b1, ST_MISS, 5'd3},
    '{'{OP_DELETE,   1'b0, 1'b0, ONES, 64'h1234_5678_0a01_0203, 8'd8}, 1, 1'b1, ST_OK, 5'd2},
    '{'{OP_VERIFY,   1'b0, 1'b0, 64'h0, 64'h0a01_0203, 8'd0}, 1, 1'b1, ST_MISS, 5'd2},
    // v4 /32 and a duplicate of it
    '{'{OP_ADD,      1'b0, 1'b0, 64'h0, 64'hffff_ffff, 8'd32}, 1, 1'b1, ST_OK, 5'd3},
    '{'{OP_ADD,      1'b0, 1'b0, 64'h0, 64'hffff_ffff, 8'd32}, 1, 1'b1, ST_OK, 5'd4},
    // fill the table, then full and bad prefix on a full table
    '{'{OP_ADD,      1'b0, 1'b1, 64'h2001_0db8_0000_0000, 64'h0, 8'd48}, 12, 1'b0, ST_OK, 5'd0},
    '{'{OP_ADD,      1'b0, 1'b0, 64'h0, 64'h0a00_0000, 8'd0}, 1, 1'b1, ST_FULL, 5'd16},
    '{'{OP_ADD,      1'b0, 1'b1, 64'h0, 64'h0, 8'd130}, 1, 1'b1, ST_BAD_PREFIX, 5'd16}
  };

  initial begin : stimulus
    word_t        w;
    int           n, r, s, i, p, pmax, roll, add_pct, del_pct;
    bit           filling;
    int           live[$];
    logic [127:0] rule_key, keep, noise, addr;
    logic [31:0]  keep32, addr32;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < $size(directed_rows); r++) begin
      repeat (directed_rows[r].reps) begin
        send_word(directed_rows[r].w, directed_rows[r].pinned, directed_rows[r].status,
                  directed_rows[r].count);
      end
    end

    // random part: phases that lean towards filling or draining the table,
    // deletes and verifies mostly built from rules actually held
    filling = 1'b1;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) filling = !filling;
      steady  = (n >= 400 && n < 560);
      add_pct = filling ? 46 : 14;
      del_pct = filling ? 14 : 46;

      live.delete();
      for (i = 0; i < TABLE_ENTRIES; i++) if (acl_valid[i]) live.push_back(i);

      w.any  = 1'b0;
      w.fam  = 1'($urandom_range(1));
      w.hi   = {$urandom, $urandom};
      w.lo   = {$urandom, $urandom};
      noise  = {$urandom, $urandom, $urandom, $urandom};
      pmax   = w.fam ? 128 : 32;
      roll   = $urandom_range(99);
      // legal prefix: zero, full width or anything in between
      r = $urandom_range(99);
      w.plen = (r < 20) ? 8'd0 : (r < 30) ? 8'(pmax) : 8'($urandom_range(pmax, 1));

      if (roll < 4) begin
        w.op   = OP_RESERVED;
        w.any  = 1'($urandom_range(1));
        w.plen = 8'($urandom_range(255));
      end else if (roll < 4 + add_pct) begin
        w.op = OP_ADD;
        r = $urandom_range(99);
        if (r < 4) begin
          w.any  = 1'b1;
          w.plen = 8'($urandom_range(255));
        end else if (r < 12) begin
          w.plen = 8'($urandom_range(255));
        end
      end else if (roll < 4 + add_pct + del_pct) begin
        w.op = OP_DELETE;
        if (live.size() > 0 && $urandom_range(99) < 80) begin
          s = live[$urandom_range(live.size() - 1)];
          w.any = acl_any[s];
          if (!acl_any[s]) begin
            w.fam = acl_family[s];
            if (acl_family[s]) begin
              w.hi = acl_hi[s];
              w.lo = acl_lo[s];
            end else begin
              w.lo = {w.lo[63:32], acl_lo[s][31:0]};
            end
            w.plen = acl_plen[s];
            // full width may also be written as zero
            if (acl_plen[s] == (acl_family[s] ? V6_MAX_PREFIX : V4_MAX_PREFIX) &&
                $urandom_range(1)) begin
              w.plen = '0;
            end
          end else begin
            w.plen = 8'($urandom_range(255));
          end
        end else begin
          w.any = ($urandom_range(99) < 8);
          if ($urandom_range(1)) w.plen = 8'($urandom_range(255));
        end
      end else begin
        w.op   = OP_VERIFY;
        w.any  = 1'($urandom_range(1));
        w.plen = 8'($urandom_range(255));
        if (live.size() > 0 && $urandom_range(99) < 75) begin
          s = live[$urandom_range(live.size() - 1)];
          if (!acl_any[s]) begin
            w.fam = ($urandom_range(99) < 10) ? !acl_family[s] : acl_family[s];
            rule_key = {acl_hi[s], acl_lo[s]};
            p = (acl_plen[s] == 0) ? 1 : acl_plen[s];
            if (w.fam) begin
              // keep the rule's prefix bits, randomise the rest, and now
              // and then break one prefix bit so it misses
              if (p > 128) p = 128;
              keep = {128{1'b1}} << (128 - p);
              addr = (rule_key & keep) | (noise & ~keep);
              if ($urandom_range(99) < 30) addr[127 - $urandom_range(p - 1)] ^= 1'b1;
              w.hi = addr[127:64];
              w.lo = addr[63:0];
            end else begin
              if (p > 32) p = 32;
              keep32 = 32'hffff_ffff << (32 - p);
              addr32 = (rule_key[31:0] & keep32) | (noise[31:0] & ~keep32);
              if ($urandom_range(99) < 30) addr32[31 - $urandom_range(p - 1)] ^= 1'b1;
              w.lo = {w.lo[63:32], addr32};
            end
          end
        end
      end
      send_word(w, 1'b0, ST_OK, 5'd0);
    end

    in_valid <= 1'b0;
    steady = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("ip_prefix_access_list test passed");
    end else begin
      $display("ip_prefix_access_list test failed");
    end
    $finish;
  end

endmodule
